// ===== design/deq_pkg.sv =====
// shared types and constants for the double-ended queue
`default_nettype none

package deq_pkg;

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int WORD_W   = 32;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_QUERY      = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_READ,
        FSM_LOAD
    } fsm_t;

endpackage

`default_nettype wire

// ===== design/deq_if.sv =====
// command and result channel interfaces of the double-ended queue
`default_nettype none

interface deq_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [deq_pkg::FUNC_W-1:0]  func;
    logic [deq_pkg::VALUE_W-1:0] value;

    modport source (output valid, func, value, input ready);
    modport sink (input valid, func, value, output ready);
endinterface

interface deq_res_if;
    logic                         valid;
    logic                         ready;
    logic [deq_pkg::STATUS_W-1:0] status;
    logic [deq_pkg::COUNT_W-1:0]  count;
    logic [deq_pkg::WORD_W-1:0]   front_word;
    logic [deq_pkg::WORD_W-1:0]   back_word;

    modport source (output valid, status, count, front_word, back_word, input ready);
    modport sink (input valid, status, count, front_word, back_word, output ready);
endinterface

`default_nettype wire

// ===== design/deq_ram.sv =====
// generic ram, one write port and two registered read ports
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// ===== design/double_ended_queue.sv =====
// double-ended queue top level: ring store in ram, pointer and count registers
//
//   channel  dir  fields                                  takes place when
//   cmd      in   func, value                             cmd.valid & cmd.ready
//   res      out  status, count, front_word, back_word    res.valid & res.ready
//
// an item passes through accept (pointer/count update and ram write),
// ram read of front and back entries, and load of the result register.
// the single write port plus the registered read set these steps.
// reset clears pointer, count, state and result valid; ram contents are not cleared.
// a result waiting in the output register does not block the next item;
// the block holds in the load step until the output register is free.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    deq_cmd_if.sink    cmd,
    deq_res_if.source  res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    deq_pkg::fsm_t    state_reg, state_next;
    logic [AW-1:0]    front_ptr_reg, front_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    deq_pkg::status_t status_reg, status_next;

    logic                          out_valid_reg, out_valid_next;
    logic [deq_pkg::STATUS_W-1:0]  out_status_reg;
    logic [deq_pkg::COUNT_W-1:0]   out_count_reg;
    logic [deq_pkg::WORD_W-1:0]    out_front_reg;
    logic [deq_pkg::WORD_W-1:0]    out_back_reg;

    logic                  accept;
    logic                  load_ok;
    logic                  full;
    logic                  empty;
    logic [AW-1:0]         front_dec;
    logic [AW-1:0]         front_inc;
    logic [AW-1:0]         back_slot;
    logic [AW-1:0]         back_idx;
    logic [CW:0]           sum_slot;
    logic [CW:0]           sum_back;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] rd_front;
    logic [DATA_WIDTH-1:0] rd_back;
    deq_pkg::op_t          op;

    assign op     = deq_pkg::op_t'(cmd.func);
    assign accept = cmd.valid && cmd.ready;
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);

    assign front_dec = (front_ptr_reg == '0) ? AW'(DEPTH - 1) : front_ptr_reg - 1'b1;
    assign front_inc = (front_ptr_reg == AW'(DEPTH - 1)) ? '0 : front_ptr_reg + 1'b1;

    // ring index of the slot just past the back entry
    assign sum_slot  = (CW + 1)'(front_ptr_reg) + (CW + 1)'(count_reg);
    assign back_slot = (sum_slot >= (CW + 1)'(DEPTH)) ? AW'(sum_slot - (CW + 1)'(DEPTH))
                                                      : AW'(sum_slot);

    // ring index of the back entry, meaningful only when not empty
    assign sum_back = sum_slot - 1'b1;
    assign back_idx = (sum_back >= (CW + 1)'(DEPTH)) ? AW'(sum_back - (CW + 1)'(DEPTH))
                                                     : AW'(sum_back);

    assign wr_data = DATA_WIDTH'(cmd.value);

    always_comb
    begin
        front_ptr_next = front_ptr_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        wr_en          = 1'b0;
        wr_addr        = back_slot;
        if (accept)
        begin
            status_next = deq_pkg::ST_OK;
            unique case (op)
                deq_pkg::OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = deq_pkg::ST_OVER;
                    end
                    else
                    begin
                        front_ptr_next = front_dec;
                        count_next     = count_reg + 1'b1;
                        wr_en          = 1'b1;
                        wr_addr        = front_dec;
                    end
                end
                deq_pkg::OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = deq_pkg::ST_OVER;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        wr_en      = 1'b1;
                        wr_addr    = back_slot;
                    end
                end
                deq_pkg::OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = deq_pkg::ST_UNDER;
                    end
                    else
                    begin
                        front_ptr_next = front_inc;
                        count_next     = count_reg - 1'b1;
                    end
                end
                deq_pkg::OP_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = deq_pkg::ST_UNDER;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                deq_pkg::OP_CLEAR:
                begin
                    front_ptr_next = '0;
                    count_next     = '0;
                end
                default:
                begin
                    // query and unused codes leave the queue as it is
                end
            endcase
        end
    end

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (front_ptr_reg),
        .rd_data_a (rd_front),
        .rd_addr_b (back_idx),
        .rd_data_b (rd_back)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            deq_pkg::FSM_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = deq_pkg::FSM_READ;
                end
            end
            deq_pkg::FSM_READ:
            begin
                state_next = deq_pkg::FSM_LOAD;
            end
            deq_pkg::FSM_LOAD:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    state_next = deq_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = deq_pkg::FSM_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        cmd.ready = 1'b0;
        load_ok   = 1'b0;
        unique case (state_reg)
            deq_pkg::FSM_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            deq_pkg::FSM_READ:
            begin
                cmd.ready = 1'b0;
            end
            deq_pkg::FSM_LOAD:
            begin
                load_ok = !out_valid_reg || res.ready;
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_ok)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= deq_pkg::FSM_IDLE;
            front_ptr_reg <= '0;
            count_reg     <= '0;
            status_reg    <= deq_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_ptr_reg <= front_ptr_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, words forced to zero when the queue is empty
    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            out_status_reg <= status_reg;
            out_count_reg  <= deq_pkg::COUNT_W'(count_reg);
            out_front_reg  <= empty ? '0 : deq_pkg::WORD_W'(rd_front);
            out_back_reg   <= empty ? '0 : deq_pkg::WORD_W'(rd_back);
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.status     = out_status_reg;
    assign res.count      = out_count_reg;
    assign res.front_word = out_front_reg;
    assign res.back_word  = out_back_reg;

endmodule

`default_nettype wire
